@@ rtl/cop_pkg.sv @@
`default_nettype none

package cop_pkg;

  localparam int MAX_SENSORS = 128;
  localparam int IDX_W       = $clog2(MAX_SENSORS);
  localparam int PRESS_W     = 16;
  localparam int COORD_W     = 16;
  localparam int PSUM_W      = 23;
  localparam int MOM_W       = 39;
  localparam int PROD_W      = PRESS_W + 1 + COORD_W;
  localparam int DCNT_W      = $clog2(MOM_W);

  localparam logic REQ_LOAD   = 1'b0;
  localparam logic REQ_SAMPLE = 1'b1;

  // controller -> datapath
  typedef struct packed {
    logic mem_wr;      // table load transfer
    logic capture;     // sample transfer: latch pressure, read table
    logic mul_en;
    logic acc_en;
    logic frame_end;   // snapshot sums, clear accumulators, start x divide
    logic div_load_y;
    logic div_step;
    logic out_load;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic s_last;
    logic psum_zero;
    logic div_last;
  } sts_t;

endpackage

`default_nettype wire

@@ rtl/cop_in_if.sv @@
`default_nettype none

interface cop_in_if;
  import cop_pkg::*;

  logic                       valid;
  logic                       ready;
  logic                       req_type;
  logic [IDX_W-1:0]           sensor_index;
  logic [PRESS_W-1:0]         pressure;
  logic signed [COORD_W-1:0]  pos_x;
  logic signed [COORD_W-1:0]  pos_y;
  logic                       include_req;
  logic                       last_of_frame;

  modport source (
    output valid, req_type, sensor_index, pressure, pos_x, pos_y, include_req,
           last_of_frame,
    input  ready
  );

  modport sink (
    input  valid, req_type, sensor_index, pressure, pos_x, pos_y, include_req,
           last_of_frame,
    output ready
  );
endinterface

`default_nettype wire

@@ rtl/cop_out_if.sv @@
`default_nettype none

interface cop_out_if;
  import cop_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [COORD_W-1:0]  cop_x;
  logic signed [COORD_W-1:0]  cop_y;
  logic                       no_load;
  logic [PSUM_W-1:0]          total_pressure;

  modport source (
    output valid, cop_x, cop_y, no_load, total_pressure,
    input  ready
  );

  modport sink (
    input  valid, cop_x, cop_y, no_load, total_pressure,
    output ready
  );
endinterface

`default_nettype wire

@@ rtl/cop_ctrl.sv @@
`default_nettype none

module cop_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  input  wire logic          in_req_type,
  output logic               in_ready,
  output logic               out_valid,
  input  wire logic          out_ready,
  input  wire cop_pkg::sts_t sts,
  output cop_pkg::cmd_t      cmd
);
  import cop_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_ACC  = 3'd2;
  localparam logic [2:0] S_FEND = 3'd3;
  localparam logic [2:0] S_DIVX = 3'd4;
  localparam logic [2:0] S_LDY  = 3'd5;
  localparam logic [2:0] S_DIVY = 3'd6;
  localparam logic [2:0] S_OUT  = 3'd7;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       out_valid_next;
  logic       in_fire;

  assign in_ready = (state == S_IDLE);
  assign in_fire  = in_valid && in_ready;

  always_comb begin
    cmd            = '0;
    state_next     = state;
    out_valid_next = out_valid && !out_ready;
    unique case (state)
      S_IDLE: begin
        if (in_fire) begin
          if (in_req_type == REQ_SAMPLE) begin
            cmd.capture = 1'b1;
            state_next  = S_MUL;
          end else begin
            cmd.mem_wr = 1'b1;
          end
        end
      end
      S_MUL: begin
        cmd.mul_en = 1'b1;
        state_next = S_ACC;
      end
      S_ACC: begin
        cmd.acc_en = 1'b1;
        state_next = sts.s_last ? S_FEND : S_IDLE;
      end
      S_FEND: begin
        cmd.frame_end = 1'b1;
        state_next    = sts.psum_zero ? S_OUT : S_DIVX;
      end
      S_DIVX: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_next = S_LDY;
        end
      end
      S_LDY: begin
        cmd.div_load_y = 1'b1;
        state_next     = S_DIVY;
      end
      S_DIVY: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid || out_ready) begin
          cmd.out_load   = 1'b1;
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

`default_nettype wire

@@ rtl/cop_dp.sv @@
`default_nettype none

module cop_dp (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire cop_pkg::cmd_t               cmd,
  output cop_pkg::sts_t                    sts,
  input  wire logic [cop_pkg::IDX_W-1:0]   sensor_index,
  input  wire logic [cop_pkg::PRESS_W-1:0] pressure,
  input  wire logic [cop_pkg::COORD_W-1:0] pos_x,
  input  wire logic [cop_pkg::COORD_W-1:0] pos_y,
  input  wire logic                        include_req,
  input  wire logic                        last_of_frame,
  output logic [cop_pkg::COORD_W-1:0]      cop_x,
  output logic [cop_pkg::COORD_W-1:0]      cop_y,
  output logic                             no_load,
  output logic [cop_pkg::PSUM_W-1:0]       total_pressure
);
  import cop_pkg::*;

  localparam logic signed [MOM_W-1:0] MOM_MAX = {1'b0, {(MOM_W-1){1'b1}}};
  localparam logic signed [MOM_W-1:0] MOM_MIN = {1'b1, {(MOM_W-1){1'b0}}};
  localparam logic [COORD_W-1:0]      C_MAX   = {1'b0, {(COORD_W-1){1'b1}}};
  localparam logic [COORD_W-1:0]      C_MIN   = {1'b1, {(COORD_W-1){1'b0}}};
  localparam logic [MOM_W-1:0]        MAG_POS = MOM_W'(C_MAX);
  localparam logic [MOM_W-1:0]        MAG_NEG = MOM_W'(C_MIN);

  // position table: x in the upper half, y in the lower
  logic [2*COORD_W-1:0] pos_mem [MAX_SENSORS];
  logic [2*COORD_W-1:0] rd_data;
  logic [MAX_SENSORS-1:0] inc_bits;

  logic [PRESS_W-1:0] s_press;
  logic               s_inc;
  logic               s_last;
  logic               p_inc;

  logic signed [PROD_W-1:0] prod_x;
  logic signed [PROD_W-1:0] prod_y;
  logic [PRESS_W-1:0]       prod_p;

  logic signed [MOM_W-1:0] mom_x;
  logic signed [MOM_W-1:0] mom_y;
  logic [PSUM_W-1:0]       psum;
  logic signed [MOM_W-1:0] mom_x_next;
  logic signed [MOM_W-1:0] mom_y_next;
  logic [PSUM_W-1:0]       psum_next;
  logic signed [MOM_W:0]   sum_x;
  logic signed [MOM_W:0]   sum_y;
  logic [PSUM_W:0]         sum_p;

  // snapshot and divider
  logic signed [MOM_W-1:0] num_y_s;
  logic [PSUM_W-1:0]       den_s;
  logic                    nl_s;
  logic [MOM_W-1:0]        div_q;
  logic [PSUM_W-1:0]       div_r;
  logic                    div_neg;
  logic                    div_sel;
  logic [DCNT_W-1:0]       div_cnt;
  logic [PSUM_W:0]         rs;
  logic                    ge;
  logic [PSUM_W-1:0]       r_next;
  logic [MOM_W-1:0]        q_next;
  logic [COORD_W-1:0]      q_clamped;
  logic [COORD_W-1:0]      res_x;
  logic [COORD_W-1:0]      res_y;

  always_ff @(posedge clk) begin
    if (cmd.mem_wr) begin
      pos_mem[sensor_index] <= {pos_x, pos_y};
    end
    if (cmd.capture) begin
      rd_data <= pos_mem[sensor_index];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      inc_bits <= '0;
    end else if (cmd.mem_wr) begin
      inc_bits[sensor_index] <= include_req;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      s_press <= pressure;
      s_inc   <= inc_bits[sensor_index];
      s_last  <= last_of_frame;
    end
    if (cmd.mul_en) begin
      prod_x <= $signed({1'b0, s_press}) * $signed(rd_data[2*COORD_W-1:COORD_W]);
      prod_y <= $signed({1'b0, s_press}) * $signed(rd_data[COORD_W-1:0]);
      prod_p <= s_press;
      p_inc  <= s_inc;
    end
  end

  // saturating accumulate
  always_comb begin
    sum_x = {mom_x[MOM_W-1], mom_x} + (MOM_W+1)'(prod_x);
    sum_y = {mom_y[MOM_W-1], mom_y} + (MOM_W+1)'(prod_y);
    sum_p = {1'b0, psum} + (PSUM_W+1)'(prod_p);
    if (sum_x[MOM_W] != sum_x[MOM_W-1]) begin
      mom_x_next = sum_x[MOM_W] ? MOM_MIN : MOM_MAX;
    end else begin
      mom_x_next = sum_x[MOM_W-1:0];
    end
    if (sum_y[MOM_W] != sum_y[MOM_W-1]) begin
      mom_y_next = sum_y[MOM_W] ? MOM_MIN : MOM_MAX;
    end else begin
      mom_y_next = sum_y[MOM_W-1:0];
    end
    psum_next = sum_p[PSUM_W] ? {PSUM_W{1'b1}} : sum_p[PSUM_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mom_x <= '0;
      mom_y <= '0;
      psum  <= '0;
    end else if (cmd.frame_end) begin
      mom_x <= '0;
      mom_y <= '0;
      psum  <= '0;
    end else if (cmd.acc_en && p_inc) begin
      mom_x <= mom_x_next;
      mom_y <= mom_y_next;
      psum  <= psum_next;
    end
  end

  // restoring divider, one quotient bit per cycle on magnitudes
  always_comb begin
    rs     = {div_r, div_q[MOM_W-1]};
    ge     = (rs >= {1'b0, den_s});
    r_next = ge ? PSUM_W'(rs - {1'b0, den_s}) : rs[PSUM_W-1:0];
    q_next = {div_q[MOM_W-2:0], ge};
    if (div_neg) begin
      q_clamped = (q_next > MAG_NEG) ? C_MIN : COORD_W'(-q_next);
    end else begin
      q_clamped = (q_next > MAG_POS) ? C_MAX : q_next[COORD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      div_cnt <= '0;
    end else if (cmd.frame_end || cmd.div_load_y) begin
      div_cnt <= '0;
    end else if (cmd.div_step) begin
      div_cnt <= div_cnt + DCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.frame_end) begin
      num_y_s <= mom_y;
      den_s   <= psum;
      nl_s    <= (psum == '0);
      div_sel <= 1'b0;
      div_r   <= '0;
      div_neg <= mom_x[MOM_W-1];
      div_q   <= mom_x[MOM_W-1] ? MOM_W'(-mom_x) : mom_x;
      if (psum == '0) begin
        res_x <= '0;
        res_y <= '0;
      end
    end else if (cmd.div_load_y) begin
      div_sel <= 1'b1;
      div_r   <= '0;
      div_neg <= num_y_s[MOM_W-1];
      div_q   <= num_y_s[MOM_W-1] ? MOM_W'(-num_y_s) : num_y_s;
    end else if (cmd.div_step) begin
      div_r <= r_next;
      div_q <= q_next;
      if (sts.div_last) begin
        if (div_sel) begin
          res_y <= q_clamped;
        end else begin
          res_x <= q_clamped;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      cop_x          <= res_x;
      cop_y          <= res_y;
      no_load        <= nl_s;
      total_pressure <= den_s;
    end
  end

  assign sts.s_last    = s_last;
  assign sts.psum_zero = (psum == '0);
  assign sts.div_last  = (div_cnt == DCNT_W'(MOM_W - 1));

endmodule

`default_nettype wire

@@ rtl/pressure_center_of_pressure.sv @@
// Steps: load transfer writes the table; sample: table read, multiply, accumulate.
// Frame-final sample: snapshot, then one shared 39-step restoring divider, x then y,
//   to the result register when the load is nonzero; when zero it skips the divides.
// Throughput: one load per cycle while idle; a sample is taken only after the last
//   is accumulated; input is held off during the divides and until the result loads.
// Reset (rst, synchronous): include bits cleared, accumulators zeroed, output empty.
`default_nettype none

module pressure_center_of_pressure (
  input  wire logic clk,
  input  wire logic rst,
  cop_in_if.sink    req,
  cop_out_if.source res
);
  import cop_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Controller: sequences capture -> multiply -> accumulate per sample and,
  // on the last sample of a frame, the snapshot and, for a nonzero load, the two divides.
  // The result register is separate, so new samples are taken while a
  // finished result still waits for its transfer.
  cop_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (req.valid),
    .in_req_type (req.req_type),
    .in_ready    (req.ready),
    .out_valid   (res.valid),
    .out_ready   (res.ready),
    .sts         (sts),
    .cmd         (cmd)
  );

  // Datapath: position table (memory) with include bits in flops, the
  // pressure*position multipliers, saturating accumulators, the divider
  // and the result register.
  cop_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .sts            (sts),
    .sensor_index   (req.sensor_index),
    .pressure       (req.pressure),
    .pos_x          (req.pos_x),
    .pos_y          (req.pos_y),
    .include_req    (req.include_req),
    .last_of_frame  (req.last_of_frame),
    .cop_x          (res.cop_x),
    .cop_y          (res.cop_y),
    .no_load        (res.no_load),
    .total_pressure (res.total_pressure)
  );

endmodule

`default_nettype wire

@@ sim/cop_centroid_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Watches both channels, keeps its own copy of the sensor table and frame sums,
// and compares each result transfer against the oldest predicted centroid.
module cop_centroid_checker (
  input  wire logic clk,
  input  wire logic rst,
  cop_in_if         req_mon,
  cop_out_if        res_mon,
  output int        mismatches,
  output int        outstanding
);
  import cop_pkg::*;

  localparam longint MOM_HI   = (longint'(1) << (MOM_W - 1)) - 1;
  localparam longint MOM_LO   = -(longint'(1) << (MOM_W - 1));
  localparam longint PSUM_MAX = (longint'(1) << PSUM_W) - 1;
  localparam longint COORD_HI = (longint'(1) << (COORD_W - 1)) - 1;
  localparam longint COORD_LO = -(longint'(1) << (COORD_W - 1));

  typedef struct {
    logic signed [COORD_W-1:0] cop_x;
    logic signed [COORD_W-1:0] cop_y;
    logic                      no_load;
    logic [PSUM_W-1:0]         total_pressure;
  } centroid_t;

  logic signed [COORD_W-1:0] pos_x_tab [MAX_SENSORS] = '{default: '0};
  logic signed [COORD_W-1:0] pos_y_tab [MAX_SENSORS] = '{default: '0};
  bit                        included  [MAX_SENSORS];

  longint moment_x       = 0;
  longint moment_y       = 0;
  longint pressure_total = 0;

  centroid_t pending_centroids [$];
  int        mismatch_total = 0;

  assign mismatches = mismatch_total;

  function automatic longint saturate_moment(longint sum);
    if (sum > MOM_HI) return MOM_HI;
    if (sum < MOM_LO) return MOM_LO;
    return sum;
  endfunction

  // truncating divide, clamped to the coordinate range
  function automatic logic signed [COORD_W-1:0] mean_coord(longint moment, longint weight);
    longint q;
    q = moment / weight;
    if (q > COORD_HI) q = COORD_HI;
    else if (q < COORD_LO) q = COORD_LO;
    return q[COORD_W-1:0];
  endfunction

  task automatic absorb_transfer();
    longint    press;
    longint    px;
    longint    py;
    int        idx;
    centroid_t c;
    idx = int'(req_mon.sensor_index);
    if (req_mon.req_type == REQ_LOAD) begin
      pos_x_tab[idx] = req_mon.pos_x;
      pos_y_tab[idx] = req_mon.pos_y;
      included[idx]  = req_mon.include_req;
    end else begin
      if (included[idx]) begin
        press          = longint'(req_mon.pressure);
        px             = longint'(pos_x_tab[idx]);
        py             = longint'(pos_y_tab[idx]);
        moment_x       = saturate_moment(moment_x + press * px);
        moment_y       = saturate_moment(moment_y + press * py);
        pressure_total = pressure_total + press;
        if (pressure_total > PSUM_MAX) pressure_total = PSUM_MAX;
      end
      if (req_mon.last_of_frame) begin
        if (pressure_total == 0) begin
          c.cop_x          = '0;
          c.cop_y          = '0;
          c.no_load        = 1'b1;
          c.total_pressure = '0;
        end else begin
          c.cop_x          = mean_coord(moment_x, pressure_total);
          c.cop_y          = mean_coord(moment_y, pressure_total);
          c.no_load        = 1'b0;
          c.total_pressure = pressure_total[PSUM_W-1:0];
        end
        pending_centroids.push_back(c);
        moment_x       = 0;
        moment_y       = 0;
        pressure_total = 0;
      end
    end
  endtask

  task automatic compare_field(input string name, input logic signed [31:0] want,
                               input logic signed [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatch_total++;
    end
  endtask

  task automatic check_centroid();
    centroid_t want;
    if (pending_centroids.size() == 0) begin
      $display("%0t: unexpected result, expected none, actual cop_x=%0d cop_y=%0d",
               $time, res_mon.cop_x, res_mon.cop_y);
      $display("%0t:   no_load=%0d total=%0d",
               $time, res_mon.no_load, res_mon.total_pressure);
      mismatch_total++;
    end else begin
      want = pending_centroids.pop_front();
      compare_field("cop_x", 32'(want.cop_x), 32'(res_mon.cop_x));
      compare_field("cop_y", 32'(want.cop_y), 32'(res_mon.cop_y));
      compare_field("no_load", 32'(want.no_load), 32'(res_mon.no_load));
      compare_field("total_pressure", 32'(want.total_pressure),
                    32'(res_mon.total_pressure));
    end
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if (res_mon.valid && res_mon.ready) check_centroid();
      if (req_mon.valid && req_mon.ready) absorb_transfer();
    end
    outstanding <= pending_centroids.size();
  end

endmodule

`default_nettype wire

@@ sim/pressure_center_of_pressure_test.sv @@
`timescale 1ns / 1ps
`default_nettype none

module pressure_center_of_pressure_test;
  import cop_pkg::*;

  // Worst case per transfer is roughly the longest send gap, the accumulate,
  // the frame-end divide and the longest sink stall; about 1500 random transfers
  // plus the directed ones. The limit sits well above that.
  localparam int CYCLE_LIMIT  = 2_000_000;
  localparam int RANDOM_ITEMS = 1500;
  // longer than divide latency plus the longest sink stall
  localparam int DRAIN_CYCLES = 200;

  logic clk        = 1'b0;
  logic rst        = 1'b1;
  logic sink_ready = 1'b0;
  int   cycle_count = 0;
  int   stall_left  = 0;
  bit   sink_eager  = 1'b0;
  bit   sender_quiet = 1'b0;
  int   sent_count  = 0;
  int   mismatches;
  int   outstanding;

  cop_in_if  req_ch();
  cop_out_if res_ch();

  assign res_ch.ready = sink_ready;

  pressure_center_of_pressure uut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .res (res_ch)
  );

  cop_centroid_checker chk (
    .clk         (clk),
    .rst         (rst),
    .req_mon     (req_ch),
    .res_mon     (res_ch),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // hard stop if the block hangs
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("pressure_center_of_pressure_test: FAIL");
      $finish;
    end
  end

  // Idle lengths: mostly none or short, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(13, 60);
  endfunction

  // Sink side: random stalls, with stretches where ready stays high.
  always @(posedge clk) begin
    if (cycle_count % 100 == 0) sink_eager <= ($urandom_range(0, 2) == 0);
    if (rst) begin
      sink_ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      sink_ready <= 1'b0;
    end else if (!sink_eager && $urandom_range(0, 3) == 0) begin
      stall_left <= pick_gap();
      sink_ready <= 1'b0;
    end else begin
      sink_ready <= 1'b1;
    end
  end

  // Bias toward the extremes of the coordinate range.
  function automatic logic signed [COORD_W-1:0] pick_coord();
    case ($urandom_range(0, 3))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      default: return COORD_W'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic logic [PRESS_W-1:0] pick_pressure();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2, 3, 4: return PRESS_W'($urandom_range(1, 255));
      default: return PRESS_W'($urandom_range(0, 65535));
    endcase
  endfunction

  // Half the traffic hits a small pool so loaded sensors get sampled often.
  function automatic logic [IDX_W-1:0] pick_index();
    if ($urandom_range(0, 1) == 0) return IDX_W'($urandom_range(0, 15));
    return IDX_W'($urandom_range(0, MAX_SENSORS - 1));
  endfunction

  // One transfer on the request channel. valid stays high into the next
  // transfer unless a gap is chosen.
  task automatic transfer_item(input logic rt, input logic [IDX_W-1:0] idx,
                               input logic [PRESS_W-1:0] p,
                               input logic signed [COORD_W-1:0] px,
                               input logic signed [COORD_W-1:0] py,
                               input logic inc, input logic last);
    int gap;
    gap = sender_quiet ? 0 : pick_gap();
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid         <= 1'b1;
    req_ch.req_type      <= rt;
    req_ch.sensor_index  <= idx;
    req_ch.pressure      <= p;
    req_ch.pos_x         <= px;
    req_ch.pos_y         <= py;
    req_ch.include_req   <= inc;
    req_ch.last_of_frame <= last;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    sent_count++;
  endtask

  // Loads carry random pressure; a last flag on a load must be ignored.
  task automatic load_sensor(input logic [IDX_W-1:0] idx,
                             input logic signed [COORD_W-1:0] px,
                             input logic signed [COORD_W-1:0] py,
                             input logic inc, input logic last);
    transfer_item(REQ_LOAD, idx, PRESS_W'($urandom_range(0, 65535)), px, py, inc, last);
  endtask

  // Samples carry random position/include bits, which must be ignored.
  task automatic sample_sensor(input logic [IDX_W-1:0] idx, input logic [PRESS_W-1:0] p,
                               input logic last);
    transfer_item(REQ_SAMPLE, idx, p, COORD_W'($urandom_range(0, 65535)),
                  COORD_W'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)), last);
  endtask

  initial begin
    int random_goal;
    int episode;
    int frame_len;
    logic [IDX_W-1:0] heavy_idx;

    req_ch.valid         <= 1'b0;
    req_ch.req_type      <= REQ_LOAD;
    req_ch.sensor_index  <= '0;
    req_ch.pressure      <= '0;
    req_ch.pos_x         <= '0;
    req_ch.pos_y         <= '0;
    req_ch.include_req   <= 1'b0;
    req_ch.last_of_frame <= 1'b0;

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // --- directed ---
    // never-loaded sensor is excluded: zero total, no_load
    sample_sensor(7'd5, 16'hFFFF, 1'b1);
    // corner positions; first load is marked last and must give nothing
    load_sensor(7'd0, 16'sh7FFF, 16'sh8000, 1'b1, 1'b1);
    load_sensor(7'd127, 16'sh8000, 16'sh7FFF, 1'b1, 1'b0);
    load_sensor(7'd64, 16'sd1000, -16'sd1000, 1'b0, 1'b1);
    // full-scale pressures, excluded sensor ends the frame
    sample_sensor(7'd0, 16'hFFFF, 1'b0);
    sample_sensor(7'd127, 16'hFFFF, 1'b0);
    sample_sensor(7'd64, 16'd1234, 1'b1);
    // included sensor with zero pressure: no_load
    sample_sensor(7'd0, 16'd0, 1'b1);
    // single unit of pressure at the negative x corner
    sample_sensor(7'd127, 16'd1, 1'b1);
    // y quotient is -8191.25: must truncate toward zero
    load_sensor(7'd1, -16'sd1, 16'sd1, 1'b1, 1'b0);
    sample_sensor(7'd1, 16'd3, 1'b0);
    sample_sensor(7'd0, 16'd1, 1'b1);
    // load in mid-frame, then sample the freshly loaded sensor
    sample_sensor(7'd64, 16'd500, 1'b0);
    load_sensor(7'd2, 16'sd12345, -16'sd6789, 1'b1, 1'b1);
    sample_sensor(7'd2, 16'd42, 1'b1);
    // re-include a sensor that was excluded
    load_sensor(7'd64, 16'sd100, 16'sd200, 1'b1, 1'b0);
    sample_sensor(7'd64, 16'd7, 1'b1);

    // --- random ---
    random_goal = sent_count + RANDOM_ITEMS;
    episode = 0;
    while (sent_count < random_goal) begin
      episode++;
      sender_quiet = ($urandom_range(0, 3) == 0);
      if (episode % 40 == 7) begin
        // long frame on one sensor: pushes pressure and moment sums toward saturation
        heavy_idx = pick_index();
        load_sensor(heavy_idx, pick_coord(), pick_coord(), 1'b1, 1'($urandom_range(0, 1)));
        frame_len = $urandom_range(129, 200);
        for (int k = 0; k < frame_len; k++)
          sample_sensor(heavy_idx, PRESS_W'($urandom_range(60000, 65535)),
                        k == frame_len - 1);
      end else begin
        if ($urandom_range(0, 2) != 0)
          repeat ($urandom_range(1, 8))
            load_sensor(pick_index(), pick_coord(), pick_coord(),
                        $urandom_range(0, 3) != 0, 1'($urandom_range(0, 1)));
        frame_len = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 40)
                                                : $urandom_range(1, 16);
        for (int k = 0; k < frame_len; k++) begin
          // stray table update inside a frame
          if ($urandom_range(0, 15) == 0)
            load_sensor(pick_index(), pick_coord(), pick_coord(),
                        1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
          sample_sensor(pick_index(), pick_pressure(), k == frame_len - 1);
        end
      end
    end

    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    // catch any stray result after the last expected one
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
    if (mismatches == 0) begin
      $display("pressure_center_of_pressure_test: PASS");
    end else begin
      $display("pressure_center_of_pressure_test: FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire

@@ files.f @@
rtl/cop_pkg.sv
rtl/cop_in_if.sv
rtl/cop_out_if.sv
rtl/cop_ctrl.sv
rtl/cop_dp.sv
rtl/pressure_center_of_pressure.sv
sim/cop_centroid_checker.sv
sim/pressure_center_of_pressure_test.sv
